### rtl/spta_pkg.sv
// ----------------------------------------------------------------------------
// spta_pkg: shared types and constants of the averaging temperature calibrator
// Field widths, the datapath digit sizes, the term codes and the per-term
// constants of the calibration polynomial.
// ----------------------------------------------------------------------------
package spta_pkg;

  // field widths
  localparam int RAW_W   = 24;
  localparam int CODE_W  = 16;
  localparam int COEF_W  = 16;
  localparam int OUT_W   = 16;
  localparam int SUM_W   = 24;
  localparam int ACC_W   = 24;
  localparam int CFG_IDX_W = 3;

  // digit-serial product register: five 16-bit digits
  localparam int DIGIT_W = 16;
  localparam int DIGITS  = 5;
  localparam int PROD_W  = DIGITS * DIGIT_W;

  // restoring divider: quotient bits, divisor width, loaded dividend width
  localparam int QUOT_W  = 21;
  localparam int QCNT_W  = $clog2(QUOT_W);
  localparam int DIV_W   = 70;
  localparam int DVD_W   = DIV_W + QUOT_W;

  // single temperature range, 1/256 degC
  localparam int TEMP_MIN = -16384;
  localparam int TEMP_MAX = 32767;

  // the offset term is 384 * k0 = (3 * k0) << 7
  localparam logic [DIGIT_W-1:0] MUL_K0 = 16'd3;

  // polynomial terms in evaluation order, same order as the register list
  typedef enum logic [CFG_IDX_W-1:0] {
    TERM_K4,
    TERM_K3,
    TERM_K2,
    TERM_K1,
    TERM_K0
  } term_t;

  localparam int TERMS = 5;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K4,
    CFG_K3,
    CFG_K2,
    CFG_K1,
    CFG_K0
  } cfg_idx_t;

  // number of multiply passes per term
  function automatic logic [2:0] term_passes(term_t t);
    logic [2:0] n;
    case (t)
      TERM_K4: n = 3'd4;
      TERM_K3: n = 3'd3;
      TERM_K2: n = 3'd2;
      TERM_K1: n = 3'd1;
      TERM_K0: n = 3'd1;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  // power-of-two scale applied before the division
  function automatic logic [3:0] term_shift(term_t t);
    logic [3:0] s;
    case (t)
      TERM_K4: s = 4'd9;
      TERM_K3: s = 4'd10;
      TERM_K2: s = 4'd9;
      TERM_K1: s = 4'd8;
      TERM_K0: s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // decimal divisor of each term
  function automatic logic [DIV_W-1:0] term_divisor(term_t t);
    logic [DIV_W-1:0] d;
    case (t)
      TERM_K4: d = 70'd1000000000000000000000;
      TERM_K3: d = 70'd10000000000000000;
      TERM_K2: d = 70'd100000000000;
      TERM_K1: d = 70'd1000000;
      TERM_K0: d = 70'd100;
      default: d = 70'd1;
    endcase
    return d;
  endfunction

  // terms that are subtracted from the temperature
  function automatic logic term_negative(term_t t);
    logic neg;
    case (t)
      TERM_K4: neg = 1'b1;
      TERM_K3: neg = 1'b0;
      TERM_K2: neg = 1'b1;
      TERM_K1: neg = 1'b0;
      TERM_K0: neg = 1'b1;
      default: neg = 1'b0;
    endcase
    return neg;
  endfunction

endpackage

### rtl/sensor_poly_temp_average_core.sv
// ----------------------------------------------------------------------------
// sensor_poly_temp_average_core: averaging polynomial temperature calibrator
// Turns raw converter readings into temperatures with a fourth-order
// calibration polynomial and emits the mean of each group of readings.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall with in_raw_reading and in_discard.
//   A transfer with in_discard high clears the partial group and gives no
//   result. Any other transfer adds one calibrated temperature.
//   Output channel: out_valid / out_stall with out_avg_temperature, one result
//   per SAMPLES_PER_AVERAGE readings, in signed units of 1/256 degC.
//   Configuration: cfg_valid / cfg_ready (always ready), cfg_index 0..4 selects
//   coef_k4..coef_k0, other indexes are ignored. Write only while idle.
// Sequence
//   Each term runs 16x16 multiply passes over 16-bit digits, a load step and a
//   bit-serial restoring division of 21 quotient bits, then an accumulation
//   step. The group sum step follows the last term; the input stalls until
//   the reading is through. The reading that closes a group adds a division
//   for the mean and an output step before the next reading is taken.
// Reset and stall
//   Reset clears the coefficients, the group sum and count and the output.
//   A stalled result sits in the output register; the next reading is taken
//   meanwhile, and a new result waits in its last state until the slot frees.
// ----------------------------------------------------------------------------
module sensor_poly_temp_average_core
  import spta_pkg::*;
#(
  parameter int SAMPLES_PER_AVERAGE = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [RAW_W-1:0]            in_raw_reading,
  input  logic                        in_discard,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_W-1:0]     out_avg_temperature,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COEF_W-1:0]           cfg_wdata
);

  localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_SUM,
    ST_OUT
  } state_t;

  // control state
  state_t                      state_r, state_nxt;
  logic [COEF_W-1:0]           coef_r [TERMS];
  logic [COEF_W-1:0]           coef_nxt [TERMS];
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]     out_avg_r, out_avg_nxt;

  // datapath
  logic [CODE_W-1:0]                 a_r, a_nxt;
  term_t                             term_r, term_nxt;
  logic [2:0]                        pass_r, pass_nxt;
  logic [2:0]                        dig_r, dig_nxt;
  logic [DIGIT_W-1:0]                carry_r, carry_nxt;
  logic [DIGITS-1:0][DIGIT_W-1:0]    prod_r, prod_nxt;
  logic [DIV_W-1:0]                  rem_r, rem_nxt;
  logic [QUOT_W-1:0]                 dq_r, dq_nxt;
  logic [QCNT_W-1:0]                 bit_cnt_r, bit_cnt_nxt;
  logic                              mean_mode_r, mean_mode_nxt;
  logic                              neg_r, neg_nxt;
  logic signed [ACC_W-1:0]           acc_r, acc_nxt;

  // combinational helpers
  logic [DIGIT_W-1:0]          mul_x;
  logic [DIGIT_W-1:0]          mul_m;
  logic [2*DIGIT_W-1:0]        mul_p;
  logic [DVD_W-1:0]            dvd;
  logic [DIV_W-1:0]            divisor;
  logic [DIV_W+1:0]            trial;
  logic [ACC_W-1:0]            quot_ext;
  logic signed [ACC_W-1:0]     sat_temp;
  logic signed [SUM_W-1:0]     sum_new;
  logic [SUM_W-1:0]            sum_mag;
  logic [CNT_W-1:0]            cnt_new;
  logic signed [OUT_W-1:0]     mean_val;

  // one digit of the multiply pass: digit times code (or 3 for the offset term) plus carry
  assign mul_x = prod_r[dig_r];
  assign mul_m = (term_r == TERM_K0) ? MUL_K0 : a_r;
  assign mul_p = 32'(mul_x) * 32'(mul_m) + 32'(carry_r);

  // scaled dividend and divisor of the shared divider
  assign dvd     = DVD_W'(prod_r) << term_shift(term_r);
  assign divisor = mean_mode_r ? DIV_W'(SAMPLES_PER_AVERAGE) : term_divisor(term_r);
  assign trial   = {1'b0, rem_r, dq_r[QUOT_W-1]} - {2'b00, divisor};

  // term quotient, single temperature clamp, group sum, count and signed mean
  assign quot_ext = ACC_W'(dq_r);
  always_comb begin
    if (acc_r < TEMP_MIN) begin
      sat_temp = ACC_W'(TEMP_MIN);
    end else if (acc_r > TEMP_MAX) begin
      sat_temp = ACC_W'(TEMP_MAX);
    end else begin
      sat_temp = acc_r;
    end
  end
  assign sum_new  = sum_r + sat_temp;
  assign sum_mag  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
  assign cnt_new  = cnt_r + CNT_W'(1);
  assign mean_val = neg_r ? -$signed(dq_r[OUT_W-1:0]) : $signed(dq_r[OUT_W-1:0]);

  // handshake outputs
  assign in_stall            = (state_r != ST_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_avg_temperature = out_avg_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    coef_nxt      = coef_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    a_nxt         = a_r;
    term_nxt      = term_r;
    pass_nxt      = pass_r;
    dig_nxt       = dig_r;
    carry_nxt     = carry_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    bit_cnt_nxt   = bit_cnt_r;
    mean_mode_nxt = mean_mode_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;

    // coefficient writes
    if (cfg_valid) begin
      case (cfg_index)
        CFG_K4:  coef_nxt[TERM_K4] = cfg_wdata;
        CFG_K3:  coef_nxt[TERM_K3] = cfg_wdata;
        CFG_K2:  coef_nxt[TERM_K2] = cfg_wdata;
        CFG_K1:  coef_nxt[TERM_K1] = cfg_wdata;
        CFG_K0:  coef_nxt[TERM_K0] = cfg_wdata;
        default: ;
      endcase
    end

    // result transfer frees the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_discard) begin
            sum_nxt = '0;
            cnt_nxt = '0;
          end else begin
            a_nxt         = in_raw_reading[RAW_W-1:RAW_W-CODE_W];
            term_nxt      = TERM_K4;
            acc_nxt       = '0;
            prod_nxt      = PROD_W'(coef_r[TERM_K4]);
            pass_nxt      = '0;
            dig_nxt       = '0;
            carry_nxt     = '0;
            mean_mode_nxt = 1'b0;
            state_nxt     = ST_MUL;
          end
        end
      end

      // one 16-bit digit per cycle, pass n covers n+1 digits
      ST_MUL: begin
        prod_nxt[dig_r] = mul_p[DIGIT_W-1:0];
        if (dig_r == pass_r) begin
          prod_nxt[3'(dig_r + 3'd1)] = mul_p[2*DIGIT_W-1:DIGIT_W];
          carry_nxt = '0;
          dig_nxt   = '0;
          if (pass_r == 3'(term_passes(term_r) - 3'd1)) begin
            state_nxt = ST_LOAD;
          end else begin
            pass_nxt = 3'(pass_r + 3'd1);
          end
        end else begin
          carry_nxt = mul_p[2*DIGIT_W-1:DIGIT_W];
          dig_nxt   = 3'(dig_r + 3'd1);
        end
      end

      // high part of the dividend starts as the remainder
      ST_LOAD: begin
        rem_nxt     = dvd[DVD_W-1:QUOT_W];
        dq_nxt      = dvd[QUOT_W-1:0];
        bit_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end

      // one quotient bit per cycle
      ST_DIV: begin
        if (!trial[DIV_W+1]) begin
          rem_nxt = trial[DIV_W-1:0];
          dq_nxt  = {dq_r[QUOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DIV_W-2:0], dq_r[QUOT_W-1]};
          dq_nxt  = {dq_r[QUOT_W-2:0], 1'b0};
        end
        if (bit_cnt_r == QCNT_W'(QUOT_W - 1)) begin
          state_nxt = mean_mode_r ? ST_OUT : ST_ACC;
        end else begin
          bit_cnt_nxt = QCNT_W'(bit_cnt_r + QCNT_W'(1));
        end
      end

      // add or subtract the truncated term, then start the next one or go on to the group sum
      ST_ACC: begin
        if (term_negative(term_r)) begin
          acc_nxt = acc_r - $signed(quot_ext);
        end else begin
          acc_nxt = acc_r + $signed(quot_ext);
        end
        if (term_r == TERM_K0) begin
          state_nxt = ST_SUM;
        end else begin
          term_nxt  = term_t'(term_r + 3'd1);
          prod_nxt  = PROD_W'(coef_r[term_t'(term_r + 3'd1)]);
          pass_nxt  = '0;
          dig_nxt   = '0;
          carry_nxt = '0;
          state_nxt = ST_MUL;
        end
      end

      // add the clamped temperature; a full group starts the mean division
      ST_SUM: begin
        if (cnt_new == CNT_W'(SAMPLES_PER_AVERAGE)) begin
          sum_nxt       = '0;
          cnt_nxt       = '0;
          neg_nxt       = sum_new[SUM_W-1];
          rem_nxt       = DIV_W'(sum_mag[SUM_W-1:QUOT_W]);
          dq_nxt        = sum_mag[QUOT_W-1:0];
          bit_cnt_nxt   = '0;
          mean_mode_nxt = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          sum_nxt   = sum_new;
          cnt_nxt   = cnt_new;
          state_nxt = ST_IDLE;
        end
      end

      // hand the mean to the output register once it is free
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_avg_nxt   = mean_val;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state, registers and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_avg_r   <= '0;
      for (int i = 0; i < TERMS; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_avg_r   <= out_avg_nxt;
      coef_r      <= coef_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    term_r      <= term_nxt;
    pass_r      <= pass_nxt;
    dig_r       <= dig_nxt;
    carry_r     <= carry_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    dq_r        <= dq_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    mean_mode_r <= mean_mode_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
  end

endmodule

### rtl/spta_checker.sv
// ----------------------------------------------------------------------------
// spta_sva_checker: port-level checks of the averaging temperature calibrator
// Watches the channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module spta_sva_checker
  import spta_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    in_discard,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] out_avg_temperature
);

  // after reset the block is idle with an empty output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // a discard transfer leaves the block ready for the next transfer
  a_discard_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_discard |=> !in_stall)
    else $error("discard transfer left the block busy");

  // a reading transfer starts the calibration
  a_reading_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_discard |=> in_stall)
    else $error("reading transfer did not start the calibration");

  // every mean lies at or above the lower end of the temperature range
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_avg_temperature) >= TEMP_MIN)
    else $error("mean below temperature range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_avg_temperature))
    else $error("stalled result changed");

endmodule

bind sensor_poly_temp_average_core spta_sva_checker u_spta_checker (.*);

### tb/spta_checker.sv
// ----------------------------------------------------------------------------
// spta_checker: result predictor and scoreboard of the temperature calibrator
// Watches the reading, result and coefficient channels, works out every group
// mean with exact wide arithmetic and compares each result transfer with the
// oldest predicted mean.
// ----------------------------------------------------------------------------
module spta_checker
  import spta_pkg::*;
#(
  parameter int SAMPLES_PER_AVERAGE = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [RAW_W-1:0]        in_raw_reading,
  input  logic                    in_discard,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [OUT_W-1:0] out_avg_temperature,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [COEF_W-1:0]       cfg_wdata,
  output int                      fail_count,
  output int                      pending_results,
  output int                      results_checked
);

  localparam int REPORT_LIMIT = 10;

  // decimal divisors of the polynomial terms
  localparam logic [127:0] DIV_QUARTIC = 128'd1000000000000000000000;
  localparam logic [127:0] DIV_CUBIC   = 128'd10000000000000000;
  localparam logic [127:0] DIV_SQUARE  = 128'd100000000000;
  localparam logic [127:0] DIV_LINEAR  = 128'd1000000;
  localparam logic [127:0] DIV_OFFSET  = 128'd100;

  logic [COEF_W-1:0] coef_k4, coef_k3, coef_k2, coef_k1, coef_k0;
  int group_sum;
  int group_count;
  logic signed [OUT_W-1:0] expected_means[$];
  int errors;
  int checked;

  // floor(k * a^power * scale / divisor), exact in 128 bits
  function automatic longint scaled_term(logic [COEF_W-1:0] k, logic [CODE_W-1:0] a,
                                         int power, int scale, logic [127:0] divisor);
    logic [127:0] acc;
    acc = 128'(k);
    for (int i = 0; i < power; i++) acc = acc * 128'(a);
    acc = acc * 128'(scale);
    acc = acc / divisor;
    return longint'(acc[62:0]);
  endfunction

  function automatic int clamp_temp(longint t);
    if (t < TEMP_MIN) return TEMP_MIN;
    if (t > TEMP_MAX) return TEMP_MAX;
    return int'(t);
  endfunction

  // calibrated temperature of one reading, 1/256 degC
  function automatic int reading_temp(logic [RAW_W-1:0] raw);
    logic [CODE_W-1:0] a;
    longint t;
    a = raw[RAW_W-1 -: CODE_W];
    t = scaled_term(coef_k3, a, 3, 1024, DIV_CUBIC)
      + scaled_term(coef_k1, a, 1, 256, DIV_LINEAR)
      - scaled_term(coef_k4, a, 4, 512, DIV_QUARTIC)
      - scaled_term(coef_k2, a, 2, 512, DIV_SQUARE)
      - scaled_term(coef_k0, a, 0, 384, DIV_OFFSET);
    return clamp_temp(t);
  endfunction

  always @(posedge clk) begin
    logic signed [OUT_W-1:0] want;
    int group_mean;
    if (!rst_n) begin
      coef_k4 = '0;
      coef_k3 = '0;
      coef_k2 = '0;
      coef_k1 = '0;
      coef_k0 = '0;
      group_sum = 0;
      group_count = 0;
      expected_means.delete();
      errors = 0;
      checked = 0;
    end else begin
      // result transfer against the oldest predicted mean
      if (out_valid && !out_stall) begin
        if (expected_means.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] unexpected result: avg_temperature %0d",
                     $realtime, out_avg_temperature);
        end else begin
          want = expected_means.pop_front();
          checked++;
          if (out_avg_temperature !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("[%0t] avg_temperature mismatch: expected %0d, got %0d",
                       $realtime, want, out_avg_temperature);
          end
        end
      end

      // reading transfer: discard clears the group, others add a temperature
      if (in_valid && !in_stall) begin
        if (in_discard) begin
          group_sum = 0;
          group_count = 0;
        end else begin
          group_sum += reading_temp(in_raw_reading);
          group_count++;
          if (group_count == SAMPLES_PER_AVERAGE) begin
            group_mean = clamp_temp(longint'(group_sum / SAMPLES_PER_AVERAGE));
            expected_means.push_back(OUT_W'(group_mean));
            group_sum = 0;
            group_count = 0;
          end
        end
      end

      // coefficient writes, unused indexes fall through
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_K4: coef_k4 = cfg_wdata;
          CFG_K3: coef_k3 = cfg_wdata;
          CFG_K2: coef_k2 = cfg_wdata;
          CFG_K1: coef_k1 = cfg_wdata;
          CFG_K0: coef_k0 = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending_results <= expected_means.size();
    results_checked <= checked;
  end

endmodule

### tb/tb_sensor_poly_temp_average_core.sv
// ----------------------------------------------------------------------------
// tb_sensor_poly_temp_average_core: testbench of the temperature calibrator
// Directed readings at the code extremes, discards and saturation, then
// random bursts of readings under a series of coefficient sets, with random
// gaps on the reading side and random stalls on the result side. A separate
// checker predicts each group mean and scores the results.
// ----------------------------------------------------------------------------
module tb_sensor_poly_temp_average_core;
  import spta_pkg::*;

  localparam int SAMPLES_PER_AVERAGE = 8;
  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_PHASES = 10;
  localparam int RANDOM_ITEMS_PER_PHASE = 123;
  localparam int NEAR_SPAN = 262143;
  localparam int TIMEOUT_CYCLES = 3000000;
  localparam logic [COEF_W-1:0] COEF_MAX = '1;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [RAW_W-1:0]        in_raw_reading;
  logic                    in_discard;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_avg_temperature;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [COEF_W-1:0]       cfg_wdata;

  int fail_count;
  int pending_results;
  int results_checked;
  int items_sent;
  int discards_sent;
  int coef_sets;

  sensor_poly_temp_average_core #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_reading     (in_raw_reading),
    .in_discard         (in_discard),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_avg_temperature(out_avg_temperature),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  spta_checker #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_reading     (in_raw_reading),
    .in_discard         (in_discard),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_avg_temperature(out_avg_temperature),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending_results    (pending_results),
    .results_checked    (results_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("timeout: %0d results still outstanding", pending_results);
    $display("== FAIL ==");
    $finish;
  end

  // result side stall pattern: free runs, choppy stretches and long holds
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 250) : $urandom_range(1, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0, 1: out_stall = 1'b0;
          2: out_stall = 1'($urandom_range(0, 1));
          default: out_stall = 1'b1;
        endcase
      end
    end
  end

  // one reading transfer, valid stays high for the next call
  task automatic send_item(input logic [RAW_W-1:0] raw, input logic drop);
    @(negedge clk);
    in_valid = 1'b1;
    in_raw_reading = raw;
    in_discard = drop;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (drop) discards_sent++;
  endtask

  task automatic idle_gap(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // stop readings, wait for all means and let the last reading finish
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] q4, q3, q2, q1, q0);
    drain_pipeline();
    write_coef(CFG_K4, q4);
    write_coef(CFG_K3, q3);
    write_coef(CFG_K2, q2);
    write_coef(CFG_K1, q1);
    write_coef(CFG_K0, q0);
    coef_sets++;
  endtask

  // coefficient mix: extremes now and then, random otherwise
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return COEF_MAX;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [RAW_W-1:0] center;
    logic [RAW_W-1:0] raw;
    logic drop;
    logic use_gaps;
    int sel;
    int burst;
    int sent;

    in_valid = 1'b0;
    in_raw_reading = '0;
    in_discard = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    items_sent = 0;
    discards_sent = 0;
    coef_sets = 1;
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // coefficients at reset: every temperature is zero
    send_item('0, 1'b0);
    send_item(RAW_MAX, 1'b0);
    send_item(RAW_W'(24'h0000FF), 1'b0);
    send_item(RAW_W'(24'hFFFF00), 1'b0);
    send_item(RAW_W'(24'h800000), 1'b0);
    send_item(RAW_W'(24'h7FFFFF), 1'b0);
    send_item(RAW_W'(24'h000100), 1'b0);
    send_item(RAW_MAX, 1'b0);

    // all coefficients at maximum, writes to unused indexes must not land
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    for (int idx = int'(CFG_K0) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_coef(CFG_IDX_W'(idx), '0);

    // discard on an empty group and in the middle of one
    send_item(RAW_MAX, 1'b1);
    send_item(RAW_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b1);

    // full group: high saturation at the top code, low at code zero
    send_item(RAW_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item(RAW_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item(RAW_MAX, 1'b0);
    send_item(RAW_W'(24'h5A5A5A), 1'b0);
    send_item(RAW_W'(24'hA5A5A5), 1'b0);
    send_item('0, 1'b0);

    // offset term alone, group left open across the next coefficient set
    load_coefs('0, '0, '0, '0, COEF_MAX);
    send_item(RAW_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item(RAW_W'(24'h123456), 1'b0);
    send_item(RAW_W'(24'hEDCBA9), 1'b0);

    // random phases: typical calibration first, then mixed coefficient sets
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        load_coefs(16'd28446, 16'd24926, 16'd36016, 16'd32791, 16'd40781);
      else
        load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
      center = RAW_W'($urandom);
      use_gaps = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < RANDOM_ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 16);
        for (int b = 0; b < burst && sent < RANDOM_ITEMS_PER_PHASE; b++) begin
          sel = $urandom_range(0, 99);
          drop = 1'b0;
          if (sel < 4) begin
            drop = 1'b1;
            raw = RAW_W'($urandom);
          end else if (sel < 10) begin
            raw = $urandom_range(0, 1) ? RAW_MAX : '0;
          end else if (sel < 50) begin
            raw = RAW_W'($urandom);
          end else begin
            // readings near a working point of this phase
            raw = center + RAW_W'($urandom_range(0, NEAR_SPAN)) - RAW_W'(NEAR_SPAN / 2);
          end
          send_item(raw, drop);
          sent++;
        end
        if (use_gaps && $urandom_range(0, 1)) idle_gap($urandom_range(1, 160));
      end
    end

    drain_pipeline();
    $display("covered %0d readings (%0d discards) under %0d coefficient sets",
             items_sent, discards_sent, coef_sets);
    $display("checked %0d group means, %0d failures, %0d means never arrived",
             results_checked, fail_count, pending_results);
    if (fail_count == 0 && pending_results == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### sensor_poly_temp_average_core.f
rtl/spta_pkg.sv
rtl/sensor_poly_temp_average_core.sv
rtl/spta_checker.sv
tb/spta_checker.sv
tb/tb_sensor_poly_temp_average_core.sv
